// ===== hw/rtl/vdn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the vector dead-zone normaliser: shared types and codes.
package vdn_pkg;

  localparam int CFG_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 1;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DEADZONE = 1'b0,
    CFG_DAMPING  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_ZERO = 2'd0,
    REGION_DAMP = 2'd1,
    REGION_NORM = 2'd2
  } region_t;

endpackage

// ===== hw/rtl/vector_deadzone_normalizer_unit.sv =====
`timescale 1ns / 1ps
// Vector dead-zone normaliser: one 2-D vector in, one scaled vector out.
//
// Input word on in_*: tdata = {vec_y, vec_x}. Output word on out_*:
// tdata = {region, out_y, out_x} padded to bytes. cfg_we writes the
// dead-zone limit (index 0) or the damping limit (index 1); change them
// only while the pipe is empty.
// The magnitude is an integer square root with one bit pair per stage,
// followed by one stage that classifies the vector and a restoring divider
// with one quotient bit per stage for both components in parallel, then an
// output register. Throughput is one word per cycle unless out_tready stalls.
// A stall on out_tready freezes the whole pipe in place; in_tready falls
// only when the output register is full and not taken, so no word is lost
// or repeated.
// Synchronous reset empties the pipe and loads limits 51 and 640.
module vector_deadzone_normalizer_unit #(
  parameter int FRAC_BITS  = 8,
  parameter int COMP_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // vec_x, vec_y
  input  logic [((2*COMP_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_x, out_y, region
  output logic [((2*COMP_WIDTH+2+7)/8)*8-1:0]   out_tdata,
  input  logic                                  cfg_we,
  input  logic [vdn_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx,
  input  logic [vdn_pkg::CFG_WIDTH-1:0]         cfg_data
);
  import vdn_pkg::*;

  localparam int CW   = COMP_WIDTH;
  localparam int RW   = 2*CW + 2;         // radicand, sum of squares
  localparam int SQN  = CW + 1;           // sqrt steps
  localparam int MW   = CW + 1;           // magnitude width
  localparam int DW   = CW + FRAC_BITS;   // dividend width
  localparam int ODW  = ((2*CW+2+7)/8)*8;
  localparam int IDW  = ((2*CW+7)/8)*8;
  localparam int LW   = (MW > CFG_WIDTH) ? MW : CFG_WIDTH;
  // ceil(2^(CW+1)/3): floor(a/3) = (a*RECIP3) >> (CW+1) for a <= 2^(CW-1)
  localparam logic [CW-1:0] RECIP3 = CW'(((64'd1 << (CW+1)) + 64'd2) / 64'd3);

  logic en;
  logic [CFG_WIDTH-1:0] dz_r, dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= CFG_WIDTH'(51);
      dp_r <= CFG_WIDTH'(640);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_DEADZONE: dz_r <= cfg_data;
        CFG_DAMPING:  dp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: squares
  logic signed [CW-1:0] ix, iy;
  logic [CW:0] ax, ay;
  logic s0_vld_r;
  logic [RW-1:0] s0_n_r;
  logic [CW-1:0] s0_x_r, s0_y_r;
  assign ix = in_tdata[CW-1:0];
  assign iy = in_tdata[2*CW-1:CW];
  assign ax = ix[CW-1] ? (CW+1)'(-{ix[CW-1], ix}) : {1'b0, ix};
  assign ay = iy[CW-1] ? (CW+1)'(-{iy[CW-1], iy}) : {1'b0, iy};

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_n_r <= RW'(ax * ax) + RW'(ay * ay);
      s0_x_r <= ix;
      s0_y_r <= iy;
    end
  end

  // square-root chain
  logic          sv [SQN+1];
  logic [RW-1:0] sn [SQN+1];
  logic [RW-1:0] sr [SQN+1];
  logic [CW-1:0] sx [SQN+1];
  logic [CW-1:0] sy [SQN+1];
  assign sv[0] = s0_vld_r;
  assign sn[0] = s0_n_r;
  assign sr[0] = '0;
  assign sx[0] = s0_x_r;
  assign sy[0] = s0_y_r;

  for (genvar g = 0; g < SQN; g++) begin : g_sqrt
    vdn_sqrt_stage #(.RW(RW), .CW(CW), .SHIFT(2*(SQN-1-g))) u_st (
      .clk, .rst_n, .en,
      .vld_i(sv[g]), .n_i(sn[g]), .res_i(sr[g]), .x_i(sx[g]), .y_i(sy[g]),
      .vld_o(sv[g+1]), .n_o(sn[g+1]), .res_o(sr[g+1]), .x_o(sx[g+1]),
      .y_o(sy[g+1])
    );
  end

  // classify stage
  logic [MW-1:0] mag;
  logic [LW-1:0] mag_l, dz_l, dp_l;
  logic [1:0] reg_c;
  logic [CW:0] cax, cay;
  logic [2*CW:0] px3, py3;
  logic [CW-1:0] fx3, fy3;
  logic c_vld_r;
  logic [1:0] c_reg_r;
  logic [MW-1:0] c_mag_r;
  logic [CW-1:0] c_x_r, c_y_r;
  logic [DW-1:0] c_ax_r, c_ay_r;
  logic [CW-1:0] c_dx_r, c_dy_r;
  logic [CW-1:0] c_dsx, c_dsy;

  assign mag   = sr[SQN][MW-1:0];
  assign mag_l = LW'(mag);
  assign dz_l  = LW'(dz_r);
  assign dp_l  = LW'(dp_r);
  assign cax   = sx[SQN][CW-1] ? (CW+1)'(-{sx[SQN][CW-1], sx[SQN]})
                               : {1'b0, sx[SQN]};
  assign cay   = sy[SQN][CW-1] ? (CW+1)'(-{sy[SQN][CW-1], sy[SQN]})
                               : {1'b0, sy[SQN]};
  // magnitude divided by three; sign goes back on in the next stage
  assign px3   = (2*CW+1)'(cax * RECIP3);
  assign py3   = (2*CW+1)'(cay * RECIP3);
  assign fx3   = px3[2*CW:CW+1];
  assign fy3   = py3[2*CW:CW+1];

  always_comb begin
    priority if (mag_l < dz_l) reg_c = REGION_ZERO;
    else if (mag_l < dp_l)     reg_c = REGION_DAMP;
    else                       reg_c = REGION_NORM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= sv[SQN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_reg_r <= reg_c;
      c_mag_r <= mag;
      c_x_r   <= sx[SQN];
      c_y_r   <= sy[SQN];
      c_ax_r  <= DW'({cax, {FRAC_BITS{1'b0}}});
      c_ay_r  <= DW'({cay, {FRAC_BITS{1'b0}}});
      c_dx_r  <= fx3;
      c_dy_r  <= fy3;
    end
  end

  assign c_dsx = c_x_r[CW-1] ? CW'(-c_dx_r) : c_dx_r;
  assign c_dsy = c_y_r[CW-1] ? CW'(-c_dy_r) : c_dy_r;

  // division chain; the damped result rides along in x/y
  logic          dv [DW+1];
  logic [DW-1:0] dqx[DW+1];
  logic [DW-1:0] dqy[DW+1];
  logic [MW:0]   drx[DW+1];
  logic [MW:0]   dry[DW+1];
  logic [MW-1:0] dmg[DW+1];
  logic [CW-1:0] dx [DW+1];
  logic [CW-1:0] dy [DW+1];
  logic [1:0]    drg[DW+1];
  assign dv[0]  = c_vld_r;
  assign dqx[0] = c_ax_r;
  assign dqy[0] = c_ay_r;
  assign drx[0] = '0;
  assign dry[0] = '0;
  assign dmg[0] = c_mag_r;
  assign dx[0]  = (c_reg_r == REGION_DAMP) ? c_dsx : c_x_r;
  assign dy[0]  = (c_reg_r == REGION_DAMP) ? c_dsy : c_y_r;
  assign drg[0] = c_reg_r;

  for (genvar g = 0; g < DW; g++) begin : g_div
    vdn_div_stage #(.DW(DW), .MW(MW), .CW(CW)) u_st (
      .clk, .rst_n, .en,
      .vld_i(dv[g]), .qx_i(dqx[g]), .qy_i(dqy[g]), .rx_i(drx[g]),
      .ry_i(dry[g]), .mag_i(dmg[g]), .x_i(dx[g]), .y_i(dy[g]),
      .reg_i(drg[g]),
      .vld_o(dv[g+1]), .qx_o(dqx[g+1]), .qy_o(dqy[g+1]), .rx_o(drx[g+1]),
      .ry_o(dry[g+1]), .mag_o(dmg[g+1]), .x_o(dx[g+1]), .y_o(dy[g+1]),
      .reg_o(drg[g+1])
    );
  end

  // output stage: sign, saturate, select
  localparam logic [DW:0] HI = (DW+1)'((1 << (CW-1)) - 1);
  logic [DW-1:0] qx, qy;
  logic [CW-1:0] ox, oy;
  logic [DW:0] qxe, qye;

  assign qx  = dqx[DW];
  assign qy  = dqy[DW];
  assign qxe = {1'b0, qx};
  assign qye = {1'b0, qy};

  function automatic logic [CW-1:0] fin(input logic [DW:0] q, input logic neg);
    logic [CW-1:0] m;
    m = CW'(HI);
    if (neg) begin
      if (q > HI) fin = ~m;
      else        fin = CW'(-q);
    end else begin
      if (q > HI) fin = m;
      else        fin = CW'(q);
    end
  endfunction

  always_comb begin
    unique case (region_t'(drg[DW]))
      REGION_ZERO: begin ox = '0; oy = '0; end
      REGION_DAMP: begin ox = dx[DW]; oy = dy[DW]; end
      REGION_NORM: begin
        if (dmg[DW] == '0) begin
          ox = '0; oy = '0;
        end else begin
          ox = fin(qxe, dx[DW][CW-1]);
          oy = fin(qye, dy[DW][CW-1]);
        end
      end
      default: begin ox = '0; oy = '0; end
    endcase
  end

  logic o_vld_r;
  logic [ODW-1:0] o_data_r;
  assign en        = !o_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (en) o_vld_r <= dv[DW];
  end
  always_ff @(posedge clk) begin
    if (en) o_data_r <= ODW'({drg[DW], oy, ox});
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;

`ifndef SYNTHESIS
  a_reg_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*CW+1:2*CW] != 2'd3)
    else $error("bad region code");
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2*CW+1:2*CW] == REGION_ZERO) |->
    out_tdata[2*CW-1:0] == '0)
    else $error("dead zone not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("output lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("stall with empty output");
`endif
endmodule

// ===== hw/rtl/vdn_sqrt_stage.sv =====
`timescale 1ns / 1ps
// One registered step of the restoring integer square root, stallable.
module vdn_sqrt_stage #(
  parameter int RW = 32,
  parameter int CW = 16,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [RW-1:0] n_i,
  input  logic [RW-1:0] res_i,
  input  logic [CW-1:0] x_i,
  input  logic [CW-1:0] y_i,
  output logic          vld_o,
  output logic [RW-1:0] n_o,
  output logic [RW-1:0] res_o,
  output logic [CW-1:0] x_o,
  output logic [CW-1:0] y_o
);
  logic [RW-1:0] bit_c;
  logic [RW-1:0] sum_c;
  logic [RW-1:0] n_nxt, res_nxt;
  logic          vld_r;
  logic [RW-1:0] n_r, res_r;
  logic [CW-1:0] x_r, y_r;

  assign bit_c = {{(RW-1){1'b0}}, 1'b1} << SHIFT;
  assign sum_c = res_i + bit_c;

  always_comb begin
    if (n_i >= sum_c) begin
      n_nxt   = n_i - sum_c;
      res_nxt = (res_i >> 1) + bit_c;
    end else begin
      n_nxt   = n_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
      x_r   <= x_i;
      y_r   <= y_i;
    end
  end

  assign vld_o = vld_r;
  assign n_o   = n_r;
  assign res_o = res_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
endmodule

// ===== hw/rtl/vdn_div_stage.sv =====
`timescale 1ns / 1ps
// One registered restoring-division step for both component quotients.
module vdn_div_stage #(
  parameter int DW = 32,
  parameter int MW = 16,
  parameter int CW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] qx_i,
  input  logic [DW-1:0] qy_i,
  input  logic [MW:0]   rx_i,
  input  logic [MW:0]   ry_i,
  input  logic [MW-1:0] mag_i,
  input  logic [CW-1:0] x_i,
  input  logic [CW-1:0] y_i,
  input  logic [1:0]    reg_i,
  output logic          vld_o,
  output logic [DW-1:0] qx_o,
  output logic [DW-1:0] qy_o,
  output logic [MW:0]   rx_o,
  output logic [MW:0]   ry_o,
  output logic [MW-1:0] mag_o,
  output logic [CW-1:0] x_o,
  output logic [CW-1:0] y_o,
  output logic [1:0]    reg_o
);
  logic [MW+1:0] tx, ty;
  logic [MW+1:0] dm;
  logic [DW-1:0] qx_nxt, qy_nxt;
  logic [MW:0]   rx_nxt, ry_nxt;
  logic          vld_r;
  logic [DW-1:0] qx_r, qy_r;
  logic [MW:0]   rx_r, ry_r;
  logic [MW-1:0] mag_r;
  logic [CW-1:0] x_r, y_r;
  logic [1:0]    reg_r;

  // quotient register holds remaining dividend bits, shifted out at the top
  assign tx = {rx_i, qx_i[DW-1]};
  assign ty = {ry_i, qy_i[DW-1]};
  assign dm = {2'b00, mag_i};

  always_comb begin
    if (tx >= dm) begin
      rx_nxt = (MW+1)'(tx - dm);
      qx_nxt = {qx_i[DW-2:0], 1'b1};
    end else begin
      rx_nxt = tx[MW:0];
      qx_nxt = {qx_i[DW-2:0], 1'b0};
    end
    if (ty >= dm) begin
      ry_nxt = (MW+1)'(ty - dm);
      qy_nxt = {qy_i[DW-2:0], 1'b1};
    end else begin
      ry_nxt = ty[MW:0];
      qy_nxt = {qy_i[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r  <= qx_nxt;
      qy_r  <= qy_nxt;
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      mag_r <= mag_i;
      x_r   <= x_i;
      y_r   <= y_i;
      reg_r <= reg_i;
    end
  end

  assign vld_o = vld_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign mag_o = mag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign reg_o = reg_r;
endmodule
